@@ rtl/prd_pkg.sv @@
// shared constants, types and helpers for the packet rate window and loss dropper
`timescale 1ns / 1ps
`default_nettype none
package prd_pkg;

  localparam int LEN_W      = 12;
  localparam int TICK_W     = 32;
  localparam int CNT_W      = 48;
  localparam int RATE_W     = 24;
  localparam int LOSS_W     = 14;
  localparam int CAP_W      = 31;
  localparam int WBYTES_W   = 32;
  localparam int RNG_W      = 32;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int VERDICT_W  = 2;

  localparam logic [LEN_W-1:0]  MAX_PACKET_BYTES = LEN_W'(2048);
  localparam logic [LOSS_W-1:0] LOSS_SCALE       = LOSS_W'(10000);
  localparam int                LOSS_SCALE_INT   = 10000;
  localparam logic [RNG_W-1:0]  SEED_RESET       = 32'hA5A5A5A5;
  localparam logic [TICK_W-1:0] WINDOW_RESET     = TICK_W'(1000000);
  localparam logic [7:0]        BYTES_PER_KBIT   = 8'd125;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RATE_LIMIT = 3'd0,
    CFG_LOSS       = 3'd1,
    CFG_WINDOW     = 3'd2,
    CFG_EGRESS     = 3'd3,
    CFG_SEED       = 3'd4
  } cfg_idx_e;

  typedef enum logic [VERDICT_W-1:0] {
    VERDICT_FORWARD   = 2'd0,
    VERDICT_RATE_DROP = 2'd1,
    VERDICT_LOSS_DROP = 2'd2,
    VERDICT_NO_EGRESS = 2'd3
  } verdict_e;

  typedef struct packed {
    logic              fire;
    logic [LEN_W-1:0]  len;
    logic [TICK_W-1:0] now;
  } pkt_step_t;

  typedef struct packed {
    logic                  rate_we;
    logic                  window_we;
    logic [CFG_DATA_W-1:0] data;
  } rate_cfg_t;

  typedef struct packed {
    logic             seed_we;
    logic             advance;
    logic [RNG_W-1:0] seed;
  } rng_ctl_t;

  // xorshift32 step, zero result maps to one
  function automatic logic [RNG_W-1:0] xorshift_next(input logic [RNG_W-1:0] x);
    logic [RNG_W-1:0] v;
    v = x ^ (x << 13);
    v = v ^ (v >> 17);
    v = v ^ (v << 5);
    return (v != '0) ? v : RNG_W'(1);
  endfunction

endpackage
`default_nettype wire

@@ rtl/prd_ifs.sv @@
// packet event and result channel interfaces
`timescale 1ns / 1ps
`default_nettype none
interface prd_pkt_if;
  import prd_pkg::*;
  logic              valid;
  logic              ready;
  logic [LEN_W-1:0]  packet_bytes;
  logic [TICK_W-1:0] now_ticks;

  modport source (output valid, output packet_bytes, output now_ticks, input ready);
  modport sink   (input valid, input packet_bytes, input now_ticks, output ready);
endinterface

interface prd_res_if;
  import prd_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [VERDICT_W-1:0] verdict;
  logic [CNT_W-1:0]     packets_in;
  logic [CNT_W-1:0]     octets_in;
  logic [CNT_W-1:0]     packets_out;
  logic [CNT_W-1:0]     octets_out;
  logic [CNT_W-1:0]     rate_drops;
  logic [CNT_W-1:0]     loss_drops;

  modport source (output valid, output verdict, output packets_in, output octets_in,
                  output packets_out, output octets_out, output rate_drops,
                  output loss_drops, input ready);
  modport sink   (input valid, input verdict, input packets_in, input octets_in,
                  input packets_out, input octets_out, input rate_drops,
                  input loss_drops, output ready);
endinterface
`default_nettype wire

@@ rtl/prd_rng.sv @@
// xorshift32 generator holding its next output and that output mod 10000
`timescale 1ns / 1ps
`default_nettype none
module prd_rng (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire prd_pkg::rng_ctl_t            ctl,
  output logic [prd_pkg::LOSS_W-1:0]        cand_mod
);
  import prd_pkg::*;

  typedef logic [LOSS_W-1:0] mod_tab_t [256];

  function automatic mod_tab_t build_mod_tab(input int unsigned weight);
    mod_tab_t t;
    for (int b = 0; b < 256; b++) begin
      t[b] = LOSS_W'((b * weight) % LOSS_SCALE_INT);
    end
    return t;
  endfunction

  localparam int unsigned W0 = 1;
  localparam int unsigned W1 = 256 % LOSS_SCALE_INT;
  localparam int unsigned W2 = 65536 % LOSS_SCALE_INT;
  localparam int unsigned W3 = 16777216 % LOSS_SCALE_INT;

  localparam mod_tab_t MOD_TAB0 = build_mod_tab(W0);
  localparam mod_tab_t MOD_TAB1 = build_mod_tab(W1);
  localparam mod_tab_t MOD_TAB2 = build_mod_tab(W2);
  localparam mod_tab_t MOD_TAB3 = build_mod_tab(W3);

  localparam logic [RNG_W-1:0]  RESET_CAND = xorshift_next(SEED_RESET);
  localparam logic [LOSS_W-1:0] RESET_MOD  = LOSS_W'(RESET_CAND % LOSS_SCALE_INT);

  localparam logic [15:0] SCALE1 = 16'(LOSS_SCALE_INT);
  localparam logic [15:0] SCALE2 = 16'(2 * LOSS_SCALE_INT);
  localparam logic [15:0] SCALE3 = 16'(3 * LOSS_SCALE_INT);

  // byte-wise residues summed, then a final range fold
  function automatic logic [LOSS_W-1:0] mod_scale(input logic [RNG_W-1:0] x);
    logic [15:0] s;
    logic [15:0] r;
    s = 16'(MOD_TAB0[x[7:0]]) + 16'(MOD_TAB1[x[15:8]])
      + 16'(MOD_TAB2[x[23:16]]) + 16'(MOD_TAB3[x[31:24]]);
    if (s >= SCALE3) begin
      r = s - SCALE3;
    end else if (s >= SCALE2) begin
      r = s - SCALE2;
    end else if (s >= SCALE1) begin
      r = s - SCALE1;
    end else begin
      r = s;
    end
    return r[LOSS_W-1:0];
  endfunction

  logic [RNG_W-1:0]  cand;
  logic [RNG_W-1:0]  cand_next;

  assign cand_next = xorshift_next(ctl.seed_we ? ctl.seed : cand);

  always_ff @(posedge clk) begin
    if (rst) begin
      cand     <= RESET_CAND;
      cand_mod <= RESET_MOD;
    end else if (ctl.seed_we || ctl.advance) begin
      cand     <= cand_next;
      cand_mod <= mod_scale(cand_next);
    end
  end

endmodule
`default_nettype wire

@@ rtl/prd_rate.sv @@
// fixed rate window: restart on expiry, byte cap check and window byte count
`timescale 1ns / 1ps
`default_nettype none
module prd_rate (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire prd_pkg::rate_cfg_t  cfg,
  input  wire prd_pkg::pkt_step_t  step,
  output logic                     reject
);
  import prd_pkg::*;

  logic                  rate_on;
  logic [CAP_W-1:0]      cap;
  logic [TICK_W-1:0]     window_ticks;
  logic                  started;
  logic [TICK_W-1:0]     window_begin;
  logic [WBYTES_W-1:0]   window_bytes;

  logic [TICK_W-1:0]     elapsed;
  logic                  expired;
  logic [WBYTES_W-1:0]   base;
  logic [WBYTES_W:0]     total;
  logic [RATE_W-1:0]     rate_wr;
  logic [CAP_W-1:0]      cap_wr;

  assign rate_wr = cfg.data[RATE_W-1:0];
  assign cap_wr  = CAP_W'(rate_wr * BYTES_PER_KBIT);

  assign elapsed = step.now - window_begin;
  assign expired = !started || (elapsed >= window_ticks);
  assign base    = expired ? '0 : window_bytes;
  assign total   = {1'b0, base} + (WBYTES_W + 1)'(step.len);
  assign reject  = rate_on && (total > (WBYTES_W + 1)'(cap));

  always_ff @(posedge clk) begin
    if (rst) begin
      rate_on      <= 1'b0;
      cap          <= '0;
      window_ticks <= WINDOW_RESET;
      started      <= 1'b0;
      window_begin <= '0;
      window_bytes <= '0;
    end else begin
      if (cfg.rate_we) begin
        rate_on      <= (rate_wr != '0);
        cap          <= cap_wr;
        started      <= 1'b0;
        window_bytes <= '0;
      end else if (step.fire && rate_on) begin
        if (expired) begin
          started      <= 1'b1;
          window_begin <= step.now;
        end
        window_bytes <= reject ? base : total[WBYTES_W-1:0];
      end
      if (cfg.window_we) begin
        window_ticks <= cfg.data[TICK_W-1:0];
      end
    end
  end

endmodule
`default_nettype wire

@@ rtl/packet_rate_window_and_loss_dropper.sv @@
// top level: input register, verdict logic, traffic counters and result register
//
//   channel  dir  handshake      payload
//   packet   in   valid/ready    packet_bytes, now_ticks
//   result   out  valid/ready    verdict, six 48-bit counters
//   cfg      in   cfg_we         cfg_index, cfg_data
//
// one packet per cycle sustained while the result side is ready; a packet passes through
// the input register, then the result register, the window and counter update being the
// loop that sets the rate
// rst is synchronous and clears the window, counters, generator and registers
// a stalled result holds the result register; the input register still empties into it
// once the result side moves, and packet.ready drops only when both are full
`timescale 1ns / 1ps
`default_nettype none
module packet_rate_window_and_loss_dropper (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_we,
  input  wire logic [prd_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [prd_pkg::CFG_DATA_W-1:0]      cfg_data,
  prd_pkt_if.sink                                  packet,
  prd_res_if.source                                result
);
  import prd_pkg::*;

  logic                 in_valid;
  logic [LEN_W-1:0]     in_len;
  logic [TICK_W-1:0]    in_now;
  logic [LEN_W-1:0]     len_clamped;

  logic [LOSS_W-1:0]    loss;
  logic                 egress;

  logic [CNT_W-1:0]     packets_in;
  logic [CNT_W-1:0]     octets_in;
  logic [CNT_W-1:0]     packets_out;
  logic [CNT_W-1:0]     octets_out;
  logic [CNT_W-1:0]     rate_drops;
  logic [CNT_W-1:0]     loss_drops;
  logic [CNT_W-1:0]     packets_in_next;
  logic [CNT_W-1:0]     octets_in_next;
  logic [CNT_W-1:0]     packets_out_next;
  logic [CNT_W-1:0]     octets_out_next;
  logic [CNT_W-1:0]     rate_drops_next;
  logic [CNT_W-1:0]     loss_drops_next;

  logic                 out_valid;
  verdict_e             out_verdict;
  verdict_e             verdict;

  logic                 advance;
  logic                 fire;
  logic                 rate_reject;
  logic                 loss_active;
  logic                 loss_reject;
  logic [LOSS_W-1:0]    cand_mod;

  rate_cfg_t            rate_cfg;
  pkt_step_t            step;
  rng_ctl_t             rng_ctl;

  assign advance      = !out_valid || result.ready;
  assign fire         = in_valid && advance;
  assign packet.ready = !in_valid || advance;

  assign len_clamped = (packet.packet_bytes > MAX_PACKET_BYTES) ? MAX_PACKET_BYTES
                                                               : packet.packet_bytes;

  // config decode
  assign rate_cfg.rate_we   = cfg_we && (cfg_index == CFG_RATE_LIMIT);
  assign rate_cfg.window_we = cfg_we && (cfg_index == CFG_WINDOW);
  assign rate_cfg.data      = cfg_data;

  assign step.fire = fire;
  assign step.len  = in_len;
  assign step.now  = in_now;

  prd_rate u_rate (
    .clk    (clk),
    .rst    (rst),
    .cfg    (rate_cfg),
    .step   (step),
    .reject (rate_reject)
  );

  assign loss_active = (loss != '0) && (loss < LOSS_SCALE);
  assign loss_reject = (loss != '0) && ((loss >= LOSS_SCALE) || (cand_mod < loss));

  assign rng_ctl.seed_we = cfg_we && (cfg_index == CFG_SEED);
  assign rng_ctl.advance = fire && !rate_reject && loss_active;
  assign rng_ctl.seed    = cfg_data[RNG_W-1:0];

  prd_rng u_rng (
    .clk      (clk),
    .rst      (rst),
    .ctl      (rng_ctl),
    .cand_mod (cand_mod)
  );

  always_comb begin
    packets_in_next  = packets_in + CNT_W'(1);
    octets_in_next   = octets_in + CNT_W'(in_len);
    packets_out_next = packets_out;
    octets_out_next  = octets_out;
    rate_drops_next  = rate_drops;
    loss_drops_next  = loss_drops;
    if (rate_reject) begin
      verdict         = VERDICT_RATE_DROP;
      rate_drops_next = rate_drops + CNT_W'(1);
    end else if (loss_reject) begin
      verdict         = VERDICT_LOSS_DROP;
      loss_drops_next = loss_drops + CNT_W'(1);
    end else if (!egress) begin
      verdict = VERDICT_NO_EGRESS;
    end else begin
      verdict          = VERDICT_FORWARD;
      packets_out_next = packets_out + CNT_W'(1);
      octets_out_next  = octets_out + CNT_W'(in_len);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      loss   <= '0;
      egress <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_LOSS:   loss   <= cfg_data[LOSS_W-1:0];
        CFG_EGRESS: egress <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (packet.ready) begin
      in_valid <= packet.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (packet.valid && packet.ready) begin
      in_len <= len_clamped;
      in_now <= packet.now_ticks;
    end
  end

  // counters and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid   <= 1'b0;
      out_verdict <= VERDICT_FORWARD;
      packets_in  <= '0;
      octets_in   <= '0;
      packets_out <= '0;
      octets_out  <= '0;
      rate_drops  <= '0;
      loss_drops  <= '0;
    end else if (advance) begin
      out_valid <= in_valid;
      if (fire) begin
        out_verdict <= verdict;
        packets_in  <= packets_in_next;
        octets_in   <= octets_in_next;
        packets_out <= packets_out_next;
        octets_out  <= octets_out_next;
        rate_drops  <= rate_drops_next;
        loss_drops  <= loss_drops_next;
      end
    end
  end

  assign result.valid       = out_valid;
  assign result.verdict     = out_verdict;
  assign result.packets_in  = packets_in;
  assign result.octets_in   = octets_in;
  assign result.packets_out = packets_out;
  assign result.octets_out  = octets_out;
  assign result.rate_drops  = rate_drops;
  assign result.loss_drops  = loss_drops;

endmodule
`default_nettype wire
